// File: rtl/hlpn_pkg.sv
// Package: constants, types and helpers for the polar line normalizer.
package hlpn_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANG_W = 36;
    localparam int CX_W  = 34;
    localparam int VX_W  = 44;
    localparam int DIV_W = 64;
    localparam int DIV_BITS = 4;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CX_W-1:0]  INV_GAIN    = 34'sd652032874;
    localparam logic [29:0]             INV_GAIN_U  = 30'd652032874;
    localparam logic [43:0]             MAG_MIN     = 44'd66;

    localparam logic [1:0] REG_FOCAL_X  = 2'd0;
    localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
    localparam logic [1:0] REG_CENTER_U = 2'd2;
    localparam logic [1:0] REG_CENTER_V = 2'd3;

    typedef struct packed {
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [VX_W-1:0]  x;
        logic signed [VX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } vec_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                0: r = 36'sd843314857;
                1: r = 36'sd497837829;
                2: r = 36'sd263043837;
                3: r = 36'sd133525159;
                4: r = 36'sd67021687;
                5: r = 36'sd33543516;
                6: r = 36'sd16775851;
                7: r = 36'sd8388437;
                8: r = 36'sd4194283;
                9: r = 36'sd2097149;
                default: r = (i <= 30) ? (36'sd1 <<< (30 - i)) : '0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/hough_line_pixel_to_normalized.sv
// Top level: polar line from pixel plane to normalized image plane.
// Throughput: one transaction per cycle; each CORDIC cell and divider cell is
// one register stage of a single pipeline that stalls as a whole when the
// output register is full and stalled. Reset clears valids and loads registers.
module hough_line_pixel_to_normalized (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] rho_pixels,
    input  logic signed [15:0] theta_pixels,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] rho_normalized,
    output logic signed [15:0] theta_normalized,
    output logic               divide_error,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import hlpn_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam int DEPTH = 2 * N + 5 + DIV_STEPS;

    logic [23:0] focal_x_reg, focal_y_reg, center_u_reg, center_v_reg;
    logic [DEPTH-1:0] vld_reg;
    logic en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 24'd153600;
            focal_y_reg  <= 24'd153600;
            center_u_reg <= 24'd81920;
            center_v_reg <= 24'd61440;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FOCAL_X:  focal_x_reg  <= cfg_data;
                REG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                REG_CENTER_U: center_u_reg <= cfg_data;
                REG_CENTER_V: center_v_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance the whole pipe unless the output holds a stalled result
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // stage 0: fold angle into the range -pi/2..pi/2
    logic signed [ANG_W-1:0] z0;
    logic flip0;
    logic signed [23:0] rho0_reg;
    always_comb
    begin
        z0 = ANG_W'(theta_pixels) <<< 17;
        flip0 = 1'b0;
        if (z0 > HALF_PI_Q30)
        begin
            z0 = z0 - PI_Q30;
            flip0 = 1'b1;
        end
        else if (z0 < -HALF_PI_Q30)
        begin
            z0 = z0 + PI_Q30;
            flip0 = 1'b1;
        end
    end

    rot_t rot_reg [0:N];
    logic [N:0] flip_pipe;
    logic signed [23:0] rho_pipe [0:N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg[0] <= '{x: INV_GAIN, y: '0, z: z0};
            flip_pipe[0] <= flip0;
            rho_pipe[0] <= rho_pixels;
            for (int k = 1; k <= N; k++)
            begin
                flip_pipe[k] <= flip_pipe[k-1];
                rho_pipe[k]  <= rho_pipe[k-1];
            end
        end
    end
    assign rho0_reg = rho_pipe[N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_rot
            hlpn_rot_cell u_cell (.clk(clk), .en(en), .idx(g),
                .din(rot_reg[g]), .dout(rot_reg[g+1]));
        end
    endgenerate

    // products to Q.16, rounded half away from zero
    function automatic logic signed [33:0] rnd22(input logic signed [59:0] p);
        logic [59:0] m;
        logic [59:0] r;
        begin
            m = p[59] ? 60'(-p) : 60'(p);
            r = (m + 60'd2097152) >> 22;
            return p[59] ? -34'(r) : 34'(r);
        end
    endfunction

    logic signed [CX_W-1:0] co, si;
    assign co = flip_pipe[N] ? -rot_reg[N].x : rot_reg[N].x;
    assign si = flip_pipe[N] ? -rot_reg[N].y : rot_reg[N].y;

    logic signed [59:0] pa_reg, pb_reg, pu_reg, pv_reg;
    logic signed [23:0] rho1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= $signed({1'b0, focal_x_reg}) * 60'(co);
            pb_reg <= $signed({1'b0, focal_y_reg}) * 60'(si);
            pu_reg <= $signed({1'b0, center_u_reg}) * 60'(co);
            pv_reg <= $signed({1'b0, center_v_reg}) * 60'(si);
            rho1_reg <= rho0_reg;
        end
    end

    logic signed [33:0] a_c, b_c;
    logic signed [35:0] num_c;
    assign a_c = rnd22(pa_reg);
    assign b_c = rnd22(pb_reg);
    assign num_c = (36'(rho1_reg) <<< 8) - 36'(rnd22(pu_reg)) - 36'(rnd22(pv_reg));

    // left half plane: turn the vector by pi
    vec_t vec_reg [0:N];
    logic signed [35:0] num_pipe [0:N];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (a_c < 0)
                vec_reg[0] <= '{x: -VX_W'(a_c), y: -VX_W'(b_c),
                                z: (b_c >= 0) ? PI_Q30 : -PI_Q30};
            else
                vec_reg[0] <= '{x: VX_W'(a_c), y: VX_W'(b_c), z: '0};
            num_pipe[0] <= num_c;
            for (int k = 1; k <= N; k++)
                num_pipe[k] <= num_pipe[k-1];
        end
    end

    generate
        for (g = 0; g < N; g++)
        begin : g_vec
            hlpn_vec_cell u_cell (.clk(clk), .en(en), .idx(g),
                .din(vec_reg[g]), .dout(vec_reg[g+1]));
        end
    endgenerate

    // magnitude gain correction, split in two partial products
    logic [43:0] xm;
    assign xm = vec_reg[N].x[VX_W-1] ? '0 : vec_reg[N].x[43:0];
    logic [58:0] hi_reg;
    logic [44:0] lo_reg;
    logic signed [ANG_W-1:0] zm_reg;
    logic signed [35:0] numm_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg <= 59'(xm[43:15]) * 59'(INV_GAIN_U);
            lo_reg <= 45'(xm[14:0]) * 45'(INV_GAIN_U);
            zm_reg <= vec_reg[N].z;
            numm_reg <= num_pipe[N];
        end
    end

    logic [59:0] mag_sum;
    logic [43:0] mag_c;
    assign mag_sum = 60'(hi_reg) + 60'(lo_reg >> 15);
    assign mag_c = 44'(mag_sum >> 15);

    // set up the division: dividend |num|*2^24 + mag/2
    logic [DIV_W-1:0] dv_num [0:DIV_STEPS];
    logic [DIV_W-1:0] dv_rem [0:DIV_STEPS];
    logic [DIV_W-1:0] dv_q   [0:DIV_STEPS];
    logic [43:0] den_pipe [0:DIV_STEPS];
    logic [DIV_STEPS:0] neg_pipe, err_pipe;
    logic signed [ANG_W-1:0] z_pipe [0:DIV_STEPS];
    logic [35:0] mn;
    assign mn = numm_reg[35] ? 36'(-numm_reg) : 36'(numm_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_num[0] <= (DIV_W'(mn) << 24) + DIV_W'(mag_c >> 1);
            dv_rem[0] <= '0;
            dv_q[0]   <= '0;
            den_pipe[0] <= mag_c;
            neg_pipe[0] <= numm_reg[35];
            err_pipe[0] <= (mag_c < MAG_MIN);
            z_pipe[0]   <= zm_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                den_pipe[k] <= den_pipe[k-1];
                neg_pipe[k] <= neg_pipe[k-1];
                err_pipe[k] <= err_pipe[k-1];
                z_pipe[k]   <= z_pipe[k-1];
            end
        end
    end

    generate
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_div
            hlpn_div_cell u_cell (.clk(clk), .en(en),
                .rem_in(dv_rem[g]), .num_in(dv_num[g]), .q_in(dv_q[g]),
                .den(den_pipe[g]),
                .rem_out(dv_rem[g+1]), .num_out(dv_num[g+1]), .q_out(dv_q[g+1]));
        end
    endgenerate

    // saturate, round angle, zero both on divide error, and load the output register
    logic [DIV_W-1:0] q;
    logic signed [31:0] rho_c;
    logic signed [ANG_W-1:0] zf;
    logic [ANG_W-1:0] zmag, zr;
    logic signed [15:0] th_c;
    assign q  = dv_q[DIV_STEPS];
    assign zf = z_pipe[DIV_STEPS];
    assign zmag = zf[ANG_W-1] ? ANG_W'(-zf) : ANG_W'(zf);
    assign zr = (zmag + 36'd65536) >> 17;
    assign th_c = zf[ANG_W-1] ? -16'(zr) : 16'(zr);
    always_comb
    begin
        if (neg_pipe[DIV_STEPS])
            rho_c = (q > DIV_W'(33'd2147483648)) ? 32'sh80000000 : -32'(q);
        else
            rho_c = (q > DIV_W'(31'h7FFFFFFF)) ? 32'sh7FFFFFFF : 32'(q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= vld_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rho_normalized   <= err_pipe[DIV_STEPS] ? '0 : rho_c;
            theta_normalized <= err_pipe[DIV_STEPS] ? '0 : th_c;
            divide_error     <= err_pipe[DIV_STEPS];
        end
    end
endmodule

// File: rtl/hlpn_rot_cell.sv
// One rotation-mode CORDIC cell with its pipeline register.
module hlpn_rot_cell (
    input  logic              clk,
    input  logic              en,
    input  int                idx,
    input  hlpn_pkg::rot_t    din,
    output hlpn_pkg::rot_t    dout
);
    import hlpn_pkg::*;

    rot_t nxt;

    // rotate toward zero residual angle
    always_comb
    begin
        if (din.z >= 0)
        begin
            nxt.x = din.x - (din.y >>> idx);
            nxt.y = din.y + (din.x >>> idx);
            nxt.z = din.z - atan_q30(idx);
        end
        else
        begin
            nxt.x = din.x + (din.y >>> idx);
            nxt.y = din.y - (din.x >>> idx);
            nxt.z = din.z + atan_q30(idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= nxt;
    end
endmodule

// File: rtl/hlpn_vec_cell.sv
// One vectoring-mode CORDIC cell with its pipeline register.
module hlpn_vec_cell (
    input  logic              clk,
    input  logic              en,
    input  int                idx,
    input  hlpn_pkg::vec_t    din,
    output hlpn_pkg::vec_t    dout
);
    import hlpn_pkg::*;

    vec_t nxt;

    // drive y toward zero
    always_comb
    begin
        if (din.y < 0)
        begin
            nxt.x = din.x - (din.y >>> idx);
            nxt.y = din.y + (din.x >>> idx);
            nxt.z = din.z - atan_q30(idx);
        end
        else
        begin
            nxt.x = din.x + (din.y >>> idx);
            nxt.y = din.y - (din.x >>> idx);
            nxt.z = din.z + atan_q30(idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout <= nxt;
    end
endmodule

// File: rtl/hlpn_div_cell.sv
// One divider cell: retires DIV_BITS quotient bits of the restoring division.
module hlpn_div_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [hlpn_pkg::DIV_W-1:0]   rem_in,
    input  logic [hlpn_pkg::DIV_W-1:0]   num_in,
    input  logic [hlpn_pkg::DIV_W-1:0]   q_in,
    input  logic [43:0]                  den,
    output logic [hlpn_pkg::DIV_W-1:0]   rem_out,
    output logic [hlpn_pkg::DIV_W-1:0]   num_out,
    output logic [hlpn_pkg::DIV_W-1:0]   q_out
);
    import hlpn_pkg::*;

    logic [DIV_W:0]   r;
    logic [DIV_W-1:0] n, q;

    // shift-subtract over DIV_BITS dividend bits
    always_comb
    begin
        r = {1'b0, rem_in};
        n = num_in;
        q = q_in;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r = {r[DIV_W-1:0], n[DIV_W-1]};
            n = {n[DIV_W-2:0], 1'b0};
            if (r >= (DIV_W+1)'(den))
            begin
                r = r - (DIV_W+1)'(den);
                q = {q[DIV_W-2:0], 1'b1};
            end
            else
                q = {q[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= r[DIV_W-1:0];
            num_out <= n;
            q_out   <= q;
        end
    end
endmodule
